/* sv/tkas_pkg.sv */
// ----------------------------------------------------------------------------
// tkas_pkg
// Shared widths, codes and types of the top-k argmax selector: item
// structs, the link record held by each ring cell and the ring controls.
// ----------------------------------------------------------------------------
package tkas_pkg;

   localparam int MAX_LINKS   = 1024;
   localparam int SCORE_BITS  = 16;
   localparam int IDX_W       = $clog2(MAX_LINKS);
   localparam int COUNT_W     = $clog2(MAX_LINKS + 1);
   localparam int ACTION_W    = 2;
   localparam int POP_W       = 20;
   localparam int SUM_W       = 30;
   localparam int INDEX_OUT_W = 10;
   localparam int LIMIT_W     = 11;

   localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_PICK  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   typedef struct packed {
      logic [ACTION_W-1:0]          action;
      logic signed [SCORE_BITS-1:0] score;
      logic [POP_W-1:0]             link_population;
   } req_type;

   typedef struct packed {
      logic [INDEX_OUT_W-1:0] link_index;
      logic [POP_W-1:0]       chosen_population;
      logic [SUM_W-1:0]       population_before;
      logic [SUM_W-1:0]       running_total;
      logic                   none_positive;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic signed [SCORE_BITS-1:0] score;
      logic [POP_W-1:0]             pop;
   } link_type;

   typedef struct packed {
      logic             shift;
      logic             load;
      logic             clr_score;
      logic [IDX_W-1:0] addr;
      link_type         wr_link;
   } ring_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                input logic [POP_W-1:0] pop);
      logic [SUM_W:0] total;
      total = {1'b0, sum} + (SUM_W + 1)'(pop);
      return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
   endfunction

endpackage

/* sv/tkas_cell.sv */
// ----------------------------------------------------------------------------
// tkas_cell
// One link slot of the ring: rotates to its neighbor during a scan, takes a
// loaded link or clears its score when addressed while the ring is parked.
// ----------------------------------------------------------------------------
module tkas_cell import tkas_pkg::*; (
   input  logic          clock,
   input  ring_ctrl_type ctrl,
   input  logic          sel,
   input  link_type      next_link,
   output link_type      link
);

   link_type link_ff;
   link_type link_in;

   always_comb begin
      link_in = link_ff;
      if (ctrl.shift) begin
         link_in = next_link;
      end else if (sel && ctrl.load) begin
         link_in = ctrl.wr_link;
      end else if (sel && ctrl.clr_score) begin
         link_in.score = '0;
      end
   end

   always_ff @(posedge clock) begin
      link_ff <= link_in;
   end

   assign link = link_ff;

endmodule

/* sv/tkas_ring.sv */
// ----------------------------------------------------------------------------
// tkas_ring
// Closed ring of link cells. One full turn brings every stored link past
// the head cell in load order and leaves the ring aligned again.
// ----------------------------------------------------------------------------
module tkas_ring import tkas_pkg::*; (
   input  logic          clock,
   input  ring_ctrl_type ctrl,
   output link_type      head
);

   link_type links [MAX_LINKS];

   for (genvar k = 0; k < MAX_LINKS; k++) begin : g_cell
      logic sel;
      assign sel = (ctrl.addr == IDX_W'(k));
      tkas_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .sel       (sel),
         .next_link (links[(k + 1) % MAX_LINKS]),
         .link      (links[k])
      );
   end

   assign head = links[0];

endmodule

/* sv/top_k_argmax_selector.sv */
// ----------------------------------------------------------------------------
// top_k_argmax_selector
// Load, clear and ignored items leave busy low.
// A pick turns the link ring once (one link per cycle at the head cell) in
// ST_SCAN, then updates the totals in ST_FINISH; busy is high in both, so no
// new item is accepted until the pick is done. The result is registered
// from ST_FINISH; the receiver cannot stall, so results never wait.
// Synchronous reset empties the table and zeroes counters and pick_limit.
// ----------------------------------------------------------------------------
module top_k_argmax_selector import tkas_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_item,
   output logic               rsp_valid,
   output rsp_type            rsp_item,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_LINKS - 1);

   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             step_ff, step_in;
   logic [COUNT_W-1:0]           entry_count_ff, entry_count_in;
   logic [LIMIT_W-1:0]           picks_done_ff, picks_done_in;
   logic [LIMIT_W-1:0]           pick_limit_ff, pick_limit_in;
   logic [SUM_W-1:0]             chosen_sum_ff, chosen_sum_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic signed [SCORE_BITS-1:0] best_score_ff, best_score_in;
   logic [POP_W-1:0]             best_pop_ff, best_pop_in;
   logic [SUM_W-1:0]             before_ff, before_in;
   logic [SUM_W-1:0]             prefix_ff, prefix_in;
   rsp_type                      rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   ring_ctrl_type ring_ctrl;
   link_type      head;
   logic          accept;
   logic          pick_go;
   logic          entry_valid;
   logic          take;
   logic [LIMIT_W-1:0] picks_next;

   tkas_ring u_ring (
      .clock (clock),
      .ctrl  (ring_ctrl),
      .head  (head)
   );

   assign accept      = start && !busy;
   assign pick_go     = accept && (req_item.action == ACT_PICK) &&
                        (picks_done_ff < pick_limit_ff);
   assign entry_valid = COUNT_W'(step_ff) < entry_count_ff;
   assign take        = entry_valid && (head.score > best_score_ff);
   assign picks_next  = picks_done_ff + LIMIT_W'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pick_go) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy                      = 1'b0;
      ring_ctrl.shift           = 1'b0;
      ring_ctrl.load            = 1'b0;
      ring_ctrl.clr_score       = 1'b0;
      ring_ctrl.addr            = entry_count_ff[IDX_W-1:0];
      ring_ctrl.wr_link.score   = req_item.score;
      ring_ctrl.wr_link.pop     = req_item.link_population;
      case (state_ff)
         ST_IDLE: begin
            ring_ctrl.load = accept && (req_item.action == ACT_LOAD) &&
                             (entry_count_ff < COUNT_W'(MAX_LINKS));
         end
         ST_SCAN: begin
            busy            = 1'b1;
            ring_ctrl.shift = 1'b1;
         end
         ST_FINISH: begin
            busy                = 1'b1;
            ring_ctrl.clr_score = (entry_count_ff != '0);
            ring_ctrl.addr      = best_idx_ff;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // datapath
   always_comb begin
      step_in        = step_ff;
      entry_count_in = entry_count_ff;
      picks_done_in  = picks_done_ff;
      pick_limit_in  = pick_limit_ff;
      chosen_sum_in  = chosen_sum_ff;
      best_idx_in    = best_idx_ff;
      best_score_in  = best_score_ff;
      best_pop_in    = best_pop_ff;
      before_in      = before_ff;
      prefix_in      = prefix_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = 1'b0;

      if (csr_valid && csr_ready) begin
         pick_limit_in = csr_data;
      end

      if (ring_ctrl.load) begin
         entry_count_in = entry_count_ff + COUNT_W'(1);
      end

      if (accept && (req_item.action == ACT_CLEAR)) begin
         entry_count_in = '0;
         picks_done_in  = '0;
         chosen_sum_in  = '0;
      end

      if (pick_go) begin
         step_in       = '0;
         best_idx_in   = '0;
         best_score_in = '0;
         best_pop_in   = '0;
         before_in     = '0;
         prefix_in     = '0;
      end

      if (state_ff == ST_SCAN) begin
         step_in   = step_ff + IDX_W'(1);
         prefix_in = sat_add(prefix_ff, head.pop);
         if (take) begin
            best_idx_in   = step_ff;
            best_score_in = head.score;
            before_in     = prefix_ff;
         end
         if (entry_valid && (take || (step_ff == '0))) begin
            best_pop_in = head.pop;
         end
      end

      if (state_ff == ST_FINISH) begin
         chosen_sum_in              = sat_add(chosen_sum_ff, best_pop_ff);
         picks_done_in              = picks_next;
         rsp_in.link_index          = INDEX_OUT_W'(best_idx_ff);
         rsp_in.chosen_population   = best_pop_ff;
         rsp_in.population_before   = before_ff;
         rsp_in.running_total       = chosen_sum_in;
         rsp_in.none_positive       = (best_score_ff == '0);
         rsp_in.last                = (picks_next == pick_limit_ff);
         rsp_valid_in               = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         picks_done_ff  <= '0;
         pick_limit_ff  <= '0;
         chosen_sum_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         picks_done_ff  <= picks_done_in;
         pick_limit_ff  <= pick_limit_in;
         chosen_sum_ff  <= chosen_sum_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      best_idx_ff   <= best_idx_in;
      best_score_ff <= best_score_in;
      best_pop_ff   <= best_pop_in;
      before_ff     <= before_in;
      prefix_ff     <= prefix_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
   assign csr_ready = 1'b1;

`ifndef NO_ASSERTIONS
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("results on adjacent cycles");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= COUNT_W'(MAX_LINKS))
      else $error("entry count beyond table size");

   a_total_covers_pick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.running_total >= SUM_W'(rsp_ff.chosen_population)))
      else $error("running total below chosen population");

   a_none_is_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.none_positive) |->
         ((rsp_ff.link_index == '0) && (rsp_ff.population_before == '0)))
      else $error("no positive score but link other than first chosen");
`endif

endmodule
